// ===== src/btpc_pkg.sv =====
// Shared types and helpers for the barometric compensation block.
// No dependencies; imported by every module of the block except btpc_mul64.
`default_nettype none

package btpc_pkg;

  // Register indexes of the configuration port
  localparam int unsigned CfgIdxW = 3;
  localparam logic [CfgIdxW-1:0] REG_TEMP_COEFFS       = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_PRESS_COEFFS_LOW  = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_PRESS_COEFFS_HIGH = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_PRESS_COEFF_LAST  = 3'd3;

  typedef struct packed {
    logic [19:0] raw_temperature;
    logic [19:0] raw_pressure;
  } in_t;

  typedef struct packed {
    logic signed [31:0] temperature_centi;
    logic signed [31:0] fine_temperature;
    logic [31:0]        pressure_q24_8;
  } out_t;

  // Calibration words, raw 16-bit fields
  typedef struct packed {
    logic [15:0] t1, t2, t3;
    logic [15:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
  } coef_t;

  // Work handed from the front end to the divider side
  typedef struct packed {
    logic [31:0] temp;
    logic [31:0] fine;
    logic [63:0] num;
    logic [63:0] den;
  } work_t;

  function automatic logic [63:0] sx16(input logic [15:0] v);
    return {{48{v[15]}}, v};
  endfunction

endpackage

`default_nettype wire

// ===== src/btpc_mul64.sv =====
// Two-stage multiplier giving the low 64 bits of a 64x64 product.
// Built from three 32x32 partial products; no package dependency.
`default_nettype none

module btpc_mul64 (
  input  wire logic        clk_i,
  input  wire logic        en_i,
  input  wire logic [63:0] a_i,
  input  wire logic [63:0] b_i,
  output logic [63:0]      p_o
);

  logic [63:0] ll_q;
  logic [31:0] lh_q, hl_q;
  logic [63:0] p_q;

  // stage 1: partial products, stage 2: combine modulo 2^64
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ll_q <= a_i[31:0] * b_i[31:0];
      lh_q <= 32'(a_i[31:0] * b_i[63:32]);
      hl_q <= 32'(a_i[63:32] * b_i[31:0]);
      p_q  <= ll_q + {lh_q + hl_q, 32'b0};
    end
  end

  assign p_o = p_q;

endmodule

`default_nettype wire

// ===== src/btpc_fifo.sv =====
// Small transaction queue between the front end and the divider side.
// Depends on btpc_pkg for the work item type.
`default_nettype none

module btpc_fifo #(
  parameter int unsigned Depth = 4
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  btpc_pkg::work_t    data_i,
  input  wire logic          pop_i,
  output btpc_pkg::work_t    data_o,
  output logic               full_o,
  output logic               empty_o
);
  import btpc_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  work_t           mem_q [Depth];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == FullCnt);
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rd_q];

  // pointer and count update
  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) wr_d = (wr_q == LastPtr) ? '0 : wr_q + 1'b1;
    if (pop_i)  rd_d = (rd_q == LastPtr) ? '0 : rd_q + 1'b1;
    if (push_i && !pop_i) cnt_d = cnt_q + 1'b1;
    else if (!push_i && pop_i) cnt_d = cnt_q - 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= data_i;
  end

  // fill level stays in range
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= FullCnt) else $error("queue count out of range");

  // fill level moves by at most one entry per cycle
  a_cnt_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == $past(cnt_q)) || (cnt_q == $past(cnt_q) + 1'b1) ||
    (cnt_q == $past(cnt_q) - 1'b1)) else $error("queue count jumped");

  // an empty queue without a push stays empty
  a_empty_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (empty_o && !push_i) |=> empty_o) else $error("queue filled without push");

endmodule

`default_nettype wire

// ===== src/btpc_front.sv =====
// Front end: accepts raw samples, runs the temperature math and prepares the
// pressure numerator and denominator. Depends on btpc_pkg and btpc_mul64.
`default_nettype none

module btpc_front (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  btpc_pkg::in_t    in_data_i,
  input  btpc_pkg::coef_t  coef_i,
  input  wire logic        q_full_i,
  output logic             push_o,
  output btpc_pkg::work_t  item_o
);
  import btpc_pkg::*;

  typedef struct packed {
    logic [31:0] temp;
    logic [31:0] fine;
    logic [19:0] adcp;
  } side_t;

  logic [14:1] fv_q;
  logic        en;

  // whole pipe advances unless the last stage is stuck on a full queue
  assign en         = !fv_q[14] || !q_full_i;
  assign in_ready_o = en;
  assign push_o     = fv_q[14] && !q_full_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fv_q <= '0;
    end else if (en) begin
      fv_q <= {fv_q[13:1], in_valid_i};
    end
  end

  logic [31:0] a1_q, d1_q;
  logic [19:0] p1_q, p2_q, p3_q, p4_q;
  logic [31:0] at2_q, dd2_q, v1_3_q, m3_q, fine4_q;
  side_t       sd_q [5:14];
  logic [63:0] w1_5_q;
  logic [63:0] sq7, x5_7, x2_7;
  logic [63:0] x5_8_q, x2_8_q, x5_9_q, x2_9_q;
  logic [63:0] sqp6_9, sqp3_9;
  logic [63:0] w2_10_q, den0_10_q;
  logic [63:0] num0_11_q, den1_11_q;
  logic [63:0] np_13, dp_13;
  logic [63:0] num14_q, den14_q;

  logic [31:0] t2x, t3x, dds, f5, fine4_d;
  logic [20:0] pp;

  assign t2x  = {{16{coef_i.t2[15]}}, coef_i.t2};
  assign t3x  = {{16{coef_i.t3[15]}}, coef_i.t3};
  assign dds  = 32'($signed(dd2_q) >>> 12);
  assign fine4_d = v1_3_q + 32'($signed(m3_q) >>> 14);
  assign f5   = {fine4_q[29:0], 2'b0} + fine4_q + 32'd128;
  assign pp   = 21'd1048576 - {1'b0, sd_q[10].adcp};

  // temperature path, 32-bit wrap-around arithmetic
  always_ff @(posedge clk_i) begin
    if (en) begin
      a1_q    <= {15'b0, in_data_i.raw_temperature[19:3]} - {15'b0, coef_i.t1, 1'b0};
      d1_q    <= {16'b0, in_data_i.raw_temperature[19:4]} - {16'b0, coef_i.t1};
      p1_q    <= in_data_i.raw_pressure;
      at2_q   <= a1_q * t2x;
      dd2_q   <= d1_q * d1_q;
      p2_q    <= p1_q;
      v1_3_q  <= 32'($signed(at2_q) >>> 11);
      m3_q    <= dds * t3x;
      p3_q    <= p2_q;
      fine4_q <= fine4_d;
      p4_q    <= p3_q;
      sd_q[5] <= '{temp: 32'($signed(f5) >>> 8), fine: fine4_q, adcp: p4_q};
      w1_5_q  <= {{32{fine4_q[31]}}, fine4_q} - 64'd128000;
      for (int k = 6; k <= 14; k++) sd_q[k] <= sd_q[k-1];
    end
  end

  // first products: w1*w1, w1*P5, w1*P2
  btpc_mul64 u_sq (.clk_i, .en_i(en), .a_i(w1_5_q), .b_i(w1_5_q), .p_o(sq7));
  btpc_mul64 u_x5 (.clk_i, .en_i(en), .a_i(w1_5_q), .b_i(sx16(coef_i.p5)), .p_o(x5_7));
  btpc_mul64 u_x2 (.clk_i, .en_i(en), .a_i(w1_5_q), .b_i(sx16(coef_i.p2)), .p_o(x2_7));

  // second products: w1^2*P6, w1^2*P3
  btpc_mul64 u_p6 (.clk_i, .en_i(en), .a_i(sq7), .b_i(sx16(coef_i.p6)), .p_o(sqp6_9));
  btpc_mul64 u_p3 (.clk_i, .en_i(en), .a_i(sq7), .b_i(sx16(coef_i.p3)), .p_o(sqp3_9));

  // sums for the numerator offset and the denominator
  always_ff @(posedge clk_i) begin
    if (en) begin
      x5_8_q    <= x5_7;
      x2_8_q    <= x2_7;
      x5_9_q    <= x5_8_q;
      x2_9_q    <= x2_8_q;
      w2_10_q   <= sqp6_9 + (x5_9_q << 17) + (sx16(coef_i.p4) << 35);
      den0_10_q <= 64'($signed(sqp3_9) >>> 8) + (x2_9_q << 12);
      num0_11_q <= ({43'b0, pp} << 31) - w2_10_q;
      den1_11_q <= 64'h0000_8000_0000_0000 + den0_10_q;
      num14_q   <= np_13;
      den14_q   <= 64'($signed(dp_13) >>> 33);
    end
  end

  btpc_mul64 u_np (.clk_i, .en_i(en), .a_i(num0_11_q), .b_i(64'd3125), .p_o(np_13));
  btpc_mul64 u_dp (.clk_i, .en_i(en), .a_i(den1_11_q), .b_i({48'b0, coef_i.p1}),
                   .p_o(dp_13));

  assign item_o = '{temp: sd_q[14].temp, fine: sd_q[14].fine,
                    num: num14_q, den: den14_q};

endmodule

`default_nettype wire

// ===== src/btpc_back.sv =====
// Back end: pipelined signed 64-bit divider and the final pressure terms.
// Depends on btpc_pkg and btpc_mul64.
`default_nettype none

module btpc_back (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  btpc_pkg::coef_t  coef_i,
  input  wire logic        q_empty_i,
  input  btpc_pkg::work_t  q_item_i,
  output logic             q_pop_o,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output btpc_pkg::out_t   out_data_o
);
  import btpc_pkg::*;

  localparam int unsigned Last = 71;

  typedef struct packed {
    logic [31:0] temp;
    logic [31:0] fine;
    logic        neg;
    logic        dz;
  } bside_t;

  logic [Last:0] vb_q;
  logic          en;

  assign en          = !vb_q[Last] || out_ready_i;
  assign q_pop_o     = en && !q_empty_i;
  assign out_valid_o = vb_q[Last];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vb_q <= '0;
    end else if (en) begin
      vb_q <= {vb_q[Last-1:0], !q_empty_i};
    end
  end

  // operand magnitudes
  logic        na, nb;
  logic [63:0] ua, ub;
  assign na = q_item_i.num[63];
  assign nb = q_item_i.den[63];
  assign ua = na ? (64'd0 - q_item_i.num) : q_item_i.num;
  assign ub = nb ? (64'd0 - q_item_i.den) : q_item_i.den;

  // restoring division, one quotient bit per stage
  logic [63:0] r_q [0:64];
  logic [63:0] a_q [0:64];
  logic [63:0] q_q [0:64];
  logic [63:0] b_q [0:64];
  bside_t      sd_q [0:Last];
  logic [64:0] rem_w [1:64];
  logic        ge_w  [1:64];

  always_comb begin
    for (int k = 1; k <= 64; k++) begin
      rem_w[k] = {r_q[k-1], a_q[k-1][63]};
      ge_w[k]  = (rem_w[k] >= {1'b0, b_q[k-1]});
    end
  end

  logic [63:0] p65_q, ps65_q, p66_q, p67_q, p68_q, p69_q;
  logic [63:0] pss67, p8p67, m9_69;
  logic [63:0] c2_68_q, c2_69_q, sum70_q;
  logic [63:0] res71;
  logic [31:0] pres71_q;

  assign res71 = 64'($signed(sum70_q) >>> 8) + (sx16(coef_i.p7) << 4);

  always_ff @(posedge clk_i) begin
    if (en) begin
      r_q[0]  <= '0;
      a_q[0]  <= ua;
      q_q[0]  <= '0;
      b_q[0]  <= ub;
      sd_q[0] <= '{temp: q_item_i.temp, fine: q_item_i.fine,
                   neg: na ^ nb, dz: (q_item_i.den == '0)};
      for (int k = 1; k <= 64; k++) begin
        r_q[k] <= ge_w[k] ? 64'(rem_w[k] - {1'b0, b_q[k-1]}) : rem_w[k][63:0];
        a_q[k] <= {a_q[k-1][62:0], 1'b0};
        q_q[k] <= {q_q[k-1][62:0], ge_w[k]};
        b_q[k] <= b_q[k-1];
      end
      for (int k = 1; k <= Last; k++) sd_q[k] <= sd_q[k-1];
      // signed quotient and its scaled copy
      p65_q   <= sd_q[64].neg ? (64'd0 - q_q[64]) : q_q[64];
      ps65_q  <= 64'($signed(sd_q[64].neg ? (64'd0 - q_q[64]) : q_q[64]) >>> 13);
      p66_q   <= p65_q;
      p67_q   <= p66_q;
      p68_q   <= p67_q;
      p69_q   <= p68_q;
      c2_68_q <= 64'($signed(p8p67) >>> 19);
      c2_69_q <= c2_68_q;
      sum70_q <= p69_q + 64'($signed(m9_69) >>> 25) + c2_69_q;
      pres71_q <= sd_q[70].dz ? 32'd0 : res71[31:0];
    end
  end

  btpc_mul64 u_ss (.clk_i, .en_i(en), .a_i(ps65_q), .b_i(ps65_q), .p_o(pss67));
  btpc_mul64 u_p8 (.clk_i, .en_i(en), .a_i(p65_q), .b_i(sx16(coef_i.p8)), .p_o(p8p67));
  btpc_mul64 u_p9 (.clk_i, .en_i(en), .a_i(pss67), .b_i(sx16(coef_i.p9)), .p_o(m9_69));

  assign out_data_o = '{temperature_centi: sd_q[Last].temp,
                        fine_temperature:  sd_q[Last].fine,
                        pressure_q24_8:    pres71_q};

endmodule

`default_nettype wire

// ===== src/baro_temp_pressure_compensation_top.sv =====
// Barometric compensation block: takes one raw temperature/pressure pair per
// cycle while in_ready_o is high and returns compensated temperature, fine
// temperature and pressure in Q24.8. Sustained rate is one transaction per
// clock while the output is not stalled. The accepting edge loads the first of
// the 14 front-end stages, which hold the temperature math and the 64-bit
// products. The last of them writes the queue. The 72 back-end stages follow;
// most of them are the radix-2 divider, which retires one quotient bit per
// stage. Coefficients are to be written through the configuration port only
// while no transaction is in flight; the block itself does not enforce this.
// Depends on btpc_pkg, btpc_front, btpc_fifo, btpc_back and btpc_mul64.
`default_nettype none

module baro_temp_pressure_compensation_top #(
  parameter int unsigned QueueDepth = 4
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  btpc_pkg::in_t                      in_data_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output btpc_pkg::out_t                     out_data_o,
  input  wire logic                          cfg_we_i,
  input  wire logic [btpc_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [63:0]                   cfg_wdata_i
);
  import btpc_pkg::*;

  logic [47:0] temp_coeffs_q;
  logic [63:0] press_lo_q, press_hi_q;
  logic [15:0] press_last_q;
  coef_t       coef;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      temp_coeffs_q <= '0;
      press_lo_q    <= '0;
      press_hi_q    <= '0;
      press_last_q  <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_TEMP_COEFFS:       temp_coeffs_q <= cfg_wdata_i[47:0];
        REG_PRESS_COEFFS_LOW:  press_lo_q    <= cfg_wdata_i;
        REG_PRESS_COEFFS_HIGH: press_hi_q    <= cfg_wdata_i;
        REG_PRESS_COEFF_LAST:  press_last_q  <= cfg_wdata_i[15:0];
        default: ;
      endcase
    end
  end

  assign coef = '{t1: temp_coeffs_q[15:0], t2: temp_coeffs_q[31:16],
                  t3: temp_coeffs_q[47:32],
                  p1: press_lo_q[15:0], p2: press_lo_q[31:16],
                  p3: press_lo_q[47:32], p4: press_lo_q[63:48],
                  p5: press_hi_q[15:0], p6: press_hi_q[31:16],
                  p7: press_hi_q[47:32], p8: press_hi_q[63:48],
                  p9: press_last_q};

  logic  push, pop, full, empty;
  work_t f_item, q_item;

  btpc_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_data_i,
    .coef_i(coef), .q_full_i(full), .push_o(push), .item_o(f_item)
  );

  btpc_fifo #(.Depth(QueueDepth)) u_fifo (
    .clk_i, .rst_ni, .push_i(push), .data_i(f_item), .pop_i(pop),
    .data_o(q_item), .full_o(full), .empty_o(empty)
  );

  btpc_back u_back (
    .clk_i, .rst_ni, .coef_i(coef), .q_empty_i(empty), .q_item_i(q_item),
    .q_pop_o(pop), .out_valid_o, .out_ready_i, .out_data_o
  );

endmodule

`default_nettype wire

// ===== sim/tb.sv =====
// Self-checking testbench for the barometric compensation block.
// Depends on btpc_pkg and baro_temp_pressure_compensation_top.
// Predicts each result from the coefficients written so far and checks it.
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import btpc_pkg::*;

  localparam logic [CfgIdxW-1:0] REG_UNUSED_FIRST = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_UNUSED_LAST  = 3'd7;
  localparam int unsigned        IdleLimit        = 20000;
  localparam int unsigned        DrainCycles      = 100;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_t  in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;
  logic cfg_we = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx = '0;
  logic [63:0] cfg_wdata = '0;

  // Shadow copy of the calibration registers
  logic [47:0] cal_temp  = '0;
  logic [63:0] cal_plow  = '0;
  logic [63:0] cal_phigh = '0;
  logic [15:0] cal_p9    = '0;

  out_t expected_results[$];
  int unsigned errors = 0;
  int unsigned items_sent = 0;
  int unsigned results_seen = 0;
  int unsigned zero_press_seen = 0;
  int unsigned idle_cycles = 0;
  int unsigned rx_stall = 0;
  bit no_idle = 1'b0;

  always #5 clk = ~clk;

  baro_temp_pressure_compensation_top uut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_wdata_i(cfg_wdata)
  );

  function automatic logic [63:0] widen16(input logic [15:0] v);
    return {{48{v[15]}}, v};
  endfunction

  // Integer compensation: 32-bit temperature path, 64-bit pressure path
  function automatic out_t compensate(input in_t s);
    logic [31:0] adc_t, t1, t2, t3, a, d, m, v1, v2, fine, temp;
    logic [63:0] adc_p, p1, p2, p3, p4, p5, p6, p7, p8, p9;
    logic [63:0] w1, w2, den, num, pv, ps, c1, c2, ua, ub, q;
    bit na, nb;
    out_t r;
    adc_t = {12'b0, s.raw_temperature};
    adc_p = {44'b0, s.raw_pressure};
    t1 = {16'b0, cal_temp[15:0]};
    t2 = {{16{cal_temp[31]}}, cal_temp[31:16]};
    t3 = {{16{cal_temp[47]}}, cal_temp[47:32]};
    p1 = {48'b0, cal_plow[15:0]};
    p2 = widen16(cal_plow[31:16]);
    p3 = widen16(cal_plow[47:32]);
    p4 = widen16(cal_plow[63:48]);
    p5 = widen16(cal_phigh[15:0]);
    p6 = widen16(cal_phigh[31:16]);
    p7 = widen16(cal_phigh[47:32]);
    p8 = widen16(cal_phigh[63:48]);
    p9 = widen16(cal_p9);

    a = (adc_t >> 3) - (t1 << 1);
    m = a * t2;
    v1 = $signed(m) >>> 11;
    d = (adc_t >> 4) - t1;
    m = d * d;
    m = $signed(m) >>> 12;
    m = m * t3;
    v2 = $signed(m) >>> 14;
    fine = v1 + v2;
    m = fine * 32'd5 + 32'd128;
    temp = $signed(m) >>> 8;

    r.temperature_centi = temp;
    r.fine_temperature  = fine;
    r.pressure_q24_8    = '0;

    w1 = {{32{fine[31]}}, fine} - 64'd128000;
    w2 = w1 * w1 * p6;
    w2 = w2 + ((w1 * p5) << 17);
    w2 = w2 + (p4 << 35);
    den = w1 * w1 * p3;
    den = $signed(den) >>> 8;
    den = den + ((w1 * p2) << 12);
    den = (64'h0000_8000_0000_0000 + den) * p1;
    den = $signed(den) >>> 33;
    if (den != 0) begin
      pv = 64'd1048576 - adc_p;
      num = ((pv << 31) - w2) * 64'd3125;
      // signed divide toward zero, most negative / -1 wraps
      na = num[63];
      nb = den[63];
      ua = na ? -num : num;
      ub = nb ? -den : den;
      q = ua / ub;
      pv = (na != nb) ? -q : q;
      ps = $signed(pv) >>> 13;
      c1 = p9 * ps * ps;
      c1 = $signed(c1) >>> 25;
      c2 = p8 * pv;
      c2 = $signed(c2) >>> 19;
      pv = pv + c1 + c2;
      pv = $signed(pv) >>> 8;
      pv = pv + (p7 << 4);
      r.pressure_q24_8 = pv[31:0];
    end
    return r;
  endfunction

  // Result checker and receiver stall draw
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      out_t e;
      results_seen++;
      if (expected_results.size() == 0) begin
        $error("unexpected result transaction");
        errors++;
      end else begin
        e = expected_results.pop_front();
        if (out_data.temperature_centi !== e.temperature_centi) begin
          $error("temperature_centi exp %0d got %0d", e.temperature_centi,
                 out_data.temperature_centi);
          errors++;
        end
        if (out_data.fine_temperature !== e.fine_temperature) begin
          $error("fine_temperature exp %0d got %0d", e.fine_temperature,
                 out_data.fine_temperature);
          errors++;
        end
        if (out_data.pressure_q24_8 !== e.pressure_q24_8) begin
          $error("pressure_q24_8 exp %0h got %0h", e.pressure_q24_8,
                 out_data.pressure_q24_8);
          errors++;
        end
        if (e.pressure_q24_8 == 0) zero_press_seen++;
      end
      rx_stall = no_idle ? 0 : $urandom_range(0, 10);
    end
  end

  // Receiver ready: low for the drawn number of cycles, then high
  always @(negedge clk) begin
    if (rx_stall > 0) begin
      out_ready = 1'b0;
      rx_stall--;
    end else begin
      out_ready = 1'b1;
    end
  end

  // Watchdog on cycles without any accepted transaction
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IdleLimit) begin
      $display("tb: done, errors");
      $finish;
    end
  end

  task automatic cfg_write(input logic [CfgIdxW-1:0] idx, input logic [63:0] data);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_idx = idx;
    cfg_wdata = data;
    case (idx)
      REG_TEMP_COEFFS:       cal_temp = data[47:0];
      REG_PRESS_COEFFS_LOW:  cal_plow = data;
      REG_PRESS_COEFFS_HIGH: cal_phigh = data;
      REG_PRESS_COEFF_LAST:  cal_p9 = data[15:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // Upper junk bits on the narrow registers must be dropped
  task automatic set_coeffs(input logic [47:0] tc, input logic [63:0] plo,
                            input logic [63:0] phi, input logic [15:0] p9);
    cfg_write(REG_TEMP_COEFFS, {16'($urandom), tc});
    cfg_write(REG_PRESS_COEFFS_LOW, plo);
    cfg_write(REG_PRESS_COEFFS_HIGH, phi);
    cfg_write(REG_PRESS_COEFF_LAST, {16'($urandom), $urandom, p9});
  endtask

  // One input transaction; valid stays high if the next gap is zero
  task automatic send_sample(input logic [19:0] rt, input logic [19:0] rp);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    in_data.raw_temperature = rt;
    in_data.raw_pressure = rp;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_results.push_back(compensate(in_data));
    items_sent++;
    @(negedge clk);
  endtask

  // Sender pauses until all results are back, then lets the pipe empty
  task automatic drain();
    in_valid = 1'b0;
    while (expected_results.size() != 0) @(negedge clk);
    repeat (DrainCycles) @(negedge clk);
  endtask

  task automatic set_typical();
    set_coeffs({16'hFC18, 16'd26435, 16'd27504},
               {16'd2855, 16'd3024, 16'hD643, 16'd36477},
               {16'hC6F8, 16'd15500, 16'hFFF9, 16'd140}, 16'd6000);
  endtask

  task automatic test_reset_defaults();
    send_sample(20'h00000, 20'h00000);
    send_sample(20'hFFFFF, 20'hFFFFF);
    send_sample(20'd519888, 20'd415148);
    drain();
  endtask

  task automatic test_typical_directed();
    set_typical();
    send_sample(20'd519888, 20'd415148);
    send_sample(20'h00000, 20'h00000);
    send_sample(20'hFFFFF, 20'hFFFFF);
    send_sample(20'h00000, 20'hFFFFF);
    send_sample(20'hFFFFF, 20'h00000);
    send_sample(20'h80000, 20'h7FFFF);
    drain();
  endtask

  // P1 of zero forces a zero denominator
  task automatic test_zero_denominator();
    set_coeffs({16'hFC18, 16'd26435, 16'd27504},
               {16'd2855, 16'd3024, 16'hD643, 16'd0},
               {16'hC6F8, 16'd15500, 16'hFFF9, 16'd140}, 16'd6000);
    send_sample(20'd519888, 20'd415148);
    send_sample(20'hFFFFF, 20'h00000);
    drain();
  endtask

  // Coefficient extremes drive both datapaths into wraparound
  task automatic test_coeff_extremes();
    set_coeffs(48'hFFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
               64'hFFFF_FFFF_FFFF_FFFF, 16'hFFFF);
    send_sample(20'hFFFFF, 20'hFFFFF);
    send_sample(20'h00000, 20'h00000);
    drain();
    set_coeffs({16'h7FFF, 16'h7FFF, 16'hFFFF}, {16'h7FFF, 16'h7FFF, 16'h7FFF, 16'hFFFF},
               {16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF}, 16'h7FFF);
    send_sample(20'hFFFFF, 20'h00000);
    send_sample(20'h00000, 20'hFFFFF);
    drain();
    set_coeffs({16'h8000, 16'h8000, 16'h0000}, {16'h8000, 16'h8000, 16'h8000, 16'h0001},
               {16'h8000, 16'h8000, 16'h8000, 16'h8000}, 16'h8000);
    send_sample(20'hFFFFF, 20'hFFFFF);
    send_sample(20'h00000, 20'h00000);
    drain();
  endtask

  // Writes to unused indexes leave the registers alone
  task automatic test_unused_index();
    set_typical();
    for (int i = REG_UNUSED_FIRST; i <= REG_UNUSED_LAST; i++)
      cfg_write(CfgIdxW'(i), {$urandom, $urandom});
    send_sample(20'd519888, 20'd415148);
    send_sample(20'd500000, 20'd300000);
    drain();
  endtask

  task automatic test_random_phases();
    for (int ph = 0; ph < 6; ph++) begin
      if (ph % 2 == 0) begin
        // near typical calibration with random low bits
        set_coeffs({16'hFC00 | 16'($urandom_range(0, 1023)), 16'd26000 + 16'($urandom_range(0, 999)),
                    16'd27000 + 16'($urandom_range(0, 999))},
                   {16'($urandom_range(2000, 4000)), 16'($urandom_range(2000, 4000)),
                    16'hD000 | 16'($urandom_range(0, 4095)), 16'd36000 + 16'($urandom_range(0, 999))},
                   {16'hC000 | 16'($urandom_range(0, 4095)), 16'd15000 + 16'($urandom_range(0, 999)),
                    16'hFFF0 | 16'($urandom_range(0, 15)), 16'($urandom_range(100, 200))},
                   16'($urandom_range(5000, 7000)));
      end else begin
        set_coeffs({16'($urandom), $urandom}, {$urandom, $urandom},
                   {$urandom, $urandom}, 16'($urandom));
      end
      no_idle = (ph == 3);
      for (int n = 0; n < 315; n++)
        send_sample(20'($urandom_range(0, 20'hFFFFF)), 20'($urandom_range(0, 20'hFFFFF)));
      drain();
      no_idle = 1'b0;
    end
  endtask

  initial begin
    repeat (7) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);
    test_reset_defaults();
    test_typical_directed();
    test_zero_denominator();
    test_coeff_extremes();
    test_unused_index();
    test_random_phases();
    drain();
    $display("tb: %0d samples sent, %0d results checked (%0d with zero pressure)",
             items_sent, results_seen, zero_press_seen);
    $display("tb: covered reset defaults, typical and extreme calibration, unused indexes");
    if (errors == 0) $display("tb: done, clean");
    else $display("tb: done, errors");
    $finish;
  end

endmodule

`default_nettype wire

// ===== sim.f =====
src/btpc_pkg.sv
src/btpc_mul64.sv
src/btpc_fifo.sv
src/btpc_front.sv
src/btpc_back.sv
src/baro_temp_pressure_compensation_top.sv
sim/tb.sv
